// ===== rtl/turtle_pen_plotter_assert.svh =====
// assertion macros for the turtle pen plotter
`ifndef TURTLE_PEN_PLOTTER_ASSERT_SVH
`define TURTLE_PEN_PLOTTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// expression must hold at every clock edge out of reset
`define TPP_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

// antecedent in one cycle implies consequent in the next
`define TPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define TPP_ASSERT(lbl, clk, rst_n, expr)
`define TPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tpp_pkg.sv =====
// shared types and constants for the turtle pen plotter
`timescale 1ns / 1ps

package tpp_pkg;

    localparam int GRID_SIZE_DEF = 64;
    localparam int OP_W          = 3;
    localparam int DIST_W        = 10;
    localparam int ROW_BITS_W    = 64;
    localparam int INDEX_W       = 6;

    typedef enum logic [OP_W-1:0] {
        OP_PEN_UP    = 3'd0,
        OP_PEN_DOWN  = 3'd1,
        OP_TURN_R    = 3'd2,
        OP_TURN_L    = 3'd3,
        OP_MOVE      = 3'd4,
        OP_PRINT     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        HEAD_RIGHT = 2'd0,
        HEAD_DOWN  = 2'd1,
        HEAD_LEFT  = 2'd2,
        HEAD_UP    = 2'd3
    } t_heading;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN
    } t_state;

    // one command item
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DIST_W-1:0] distance;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [ROW_BITS_W-1:0] row_bits;
        logic [INDEX_W-1:0]    row_index;
        logic                  last_row;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic sweep;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_sweep;
        logic sweep_last;
    } t_dp_status;

endpackage

// ===== rtl/tpp_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module tpp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tpp_ctrl.sv =====
// command sequencer for the turtle pen plotter
`timescale 1ns / 1ps

module tpp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tpp_pkg::t_dp_status i_status,
    output tpp_pkg::t_ctl_cmd   o_ctl,
    output logic                o_busy
);

    import tpp_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_ctl.accept = 1'b0;
        o_ctl.sweep  = 1'b0;
        o_busy       = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy       = 1'b0;
                o_ctl.accept = i_start;
                if (i_start && i_status.need_sweep) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                o_ctl.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tpp_datapath.sv =====
// pen state, bitmap storage and row sweep datapath
`timescale 1ns / 1ps

module tpp_datapath #(
    parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tpp_pkg::t_cmd       i_cmd,
    input  tpp_pkg::t_ctl_cmd   i_ctl,
    output tpp_pkg::t_dp_status o_status,
    output logic                o_strobe,
    output tpp_pkg::t_result    o_result
);

    import tpp_pkg::*;

    localparam int AW = $clog2(GRID_SIZE);
    localparam int CW = $clog2(GRID_SIZE + 1);
    localparam logic [AW-1:0] LAST = AW'(GRID_SIZE - 1);

    // pen state
    logic                 r_pen;
    t_heading             r_heading;
    logic [AW-1:0]        r_row;
    logic [AW-1:0]        r_col;
    logic [GRID_SIZE-1:0] r_valid;

    // sweep state
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_addr;
    logic [GRID_SIZE-1:0] r_mask;
    logic                 r_down;
    logic                 r_print;

    // write-back / output stage
    logic                 r_p_act;
    logic [AW-1:0]        r_p_addr;
    logic                 r_p_print;
    logic                 r_rd_valid;

    t_op                  op;
    logic [AW-1:0]        room;
    logic [AW-1:0]        steps;
    logic [GRID_SIZE-1:0] hmask;
    logic                 n_need;
    logic [CW-1:0]        n_count;
    logic [AW-1:0]        n_addr;
    logic [GRID_SIZE-1:0] n_mask;
    logic                 n_down;
    logic [GRID_SIZE-1:0] ram_rdata;
    logic [GRID_SIZE-1:0] row_data;
    logic                 wr_en;

    assign op = t_op'(i_cmd.op);

    // room to the edge and clipped step count
    always_comb begin
        case (r_heading)
            HEAD_RIGHT: room = LAST - r_col;
            HEAD_DOWN:  room = LAST - r_row;
            HEAD_LEFT:  room = r_col;
            HEAD_UP:    room = r_row;
            default:    room = r_row;
        endcase
        if (i_cmd.distance < DIST_W'(room)) begin
            steps = i_cmd.distance[AW-1:0];
        end else begin
            steps = room;
        end
    end

    // columns entered by a horizontal move
    always_comb begin
        for (int c = 0; c < GRID_SIZE; c++) begin
            if (r_heading == HEAD_RIGHT) begin
                hmask[c] = (AW'(c) > r_col) && (AW'(c) <= r_col + steps);
            end else begin
                hmask[c] = (AW'(c) >= r_col - steps) && (AW'(c) < r_col);
            end
        end
    end

    // sweep setup for the command on the input
    always_comb begin
        n_need  = 1'b0;
        n_count = CW'(1);
        n_addr  = r_row;
        n_mask  = hmask;
        n_down  = 1'b1;
        case (op)
            OP_PRINT: begin
                n_need  = 1'b1;
                n_count = CW'(GRID_SIZE);
                n_addr  = '0;
                n_mask  = '0;
            end
            OP_MOVE: begin
                n_need = r_pen && (steps != '0);
                if (r_heading == HEAD_DOWN) begin
                    n_count = CW'(steps);
                    n_addr  = r_row + AW'(1);
                    n_mask  = GRID_SIZE'(1) << r_col;
                end else if (r_heading == HEAD_UP) begin
                    n_count = CW'(steps);
                    n_addr  = r_row - AW'(1);
                    n_mask  = GRID_SIZE'(1) << r_col;
                    n_down  = 1'b0;
                end
            end
            default: begin
                n_need = 1'b0;
            end
        endcase
    end

    assign o_status.need_sweep = n_need;
    assign o_status.sweep_last = (r_count == CW'(1));

    // pen state, sweep counter, valid bits and stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen     <= 1'b0;
            r_heading <= HEAD_RIGHT;
            r_row     <= '0;
            r_col     <= '0;
            r_valid   <= '0;
            r_count   <= '0;
            r_p_act   <= 1'b0;
        end else begin
            r_p_act <= i_ctl.sweep;
            if (i_ctl.accept) begin
                r_count <= n_count;
                case (op)
                    OP_PEN_UP:   r_pen <= 1'b0;
                    OP_PEN_DOWN: r_pen <= 1'b1;
                    OP_TURN_R:   r_heading <= t_heading'(r_heading + 2'd1);
                    OP_TURN_L:   r_heading <= t_heading'(r_heading + 2'd3);
                    OP_MOVE: begin
                        case (r_heading)
                            HEAD_RIGHT: r_col <= r_col + steps;
                            HEAD_DOWN:  r_row <= r_row + steps;
                            HEAD_LEFT:  r_col <= r_col - steps;
                            HEAD_UP:    r_row <= r_row - steps;
                            default:    r_row <= r_row;
                        endcase
                    end
                    default: begin
                        r_pen <= r_pen;
                    end
                endcase
            end else if (i_ctl.sweep) begin
                r_count <= r_count - CW'(1);
            end
            if (wr_en) begin
                r_valid[r_p_addr] <= 1'b1;
            end
        end
    end

    // sweep address and stage payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_addr  <= n_addr;
            r_mask  <= n_mask;
            r_down  <= n_down;
            r_print <= (op == OP_PRINT);
        end else if (i_ctl.sweep) begin
            r_addr <= r_down ? r_addr + AW'(1) : r_addr - AW'(1);
        end
        r_p_addr   <= r_addr;
        r_p_print  <= r_print;
        r_rd_valid <= r_valid[r_addr];
    end

    // bitmap rows; a row never written reads as cleared
    tpp_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (GRID_SIZE)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_p_addr),
        .i_wdata (row_data | r_mask),
        .i_re    (i_ctl.sweep),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign row_data = r_rd_valid ? ram_rdata : '0;
    assign wr_en    = r_p_act && !r_p_print;

    // result item
    assign o_strobe           = r_p_act && r_p_print;
    assign o_result.row_bits  = ROW_BITS_W'(row_data);
    assign o_result.row_index = INDEX_W'(r_p_addr);
    assign o_result.last_row  = (r_p_addr == LAST);

endmodule

// ===== rtl/turtle_pen_plotter.sv =====
// turtle pen plotter top level: sequencer plus datapath
`timescale 1ns / 1ps

// Turtle-graphics pen engine over a GRID_SIZE by GRID_SIZE one-bit bitmap.
// A command item is taken when start is high and busy is low. Pen up, pen
// down, turns, pen-up moves and moves that go nowhere finish in the cycle
// they are taken and busy stays low. A pen-down move or a print keeps busy
// high through the sweep state, which reads one row for a horizontal move,
// one row per clipped step of a vertical move and every row for a print,
// and then through the drain state; the next item can be taken once busy
// is low. The busy time comes from the single read port of the bitmap
// memory, which gives up one row per cycle. A print puts out its rows top
// to bottom on consecutive cycles, each row on o_strobe after its registered
// read, with last_row set on the bottom row. There is no back-pressure: the
// receiver must take every row on the cycle its strobe is high. The bitmap is
// cleared at reset through per-row valid bits, so there is no clearing pass and commands are taken right away.

module turtle_pen_plotter #(
    parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tpp_pkg::t_cmd    i_cmd,
    output logic             o_strobe,
    output tpp_pkg::t_result o_result
);

    import tpp_pkg::*;

    `include "turtle_pen_plotter_assert.svh"

    t_ctl_cmd   ctl;
    t_dp_status status;

    // command sequencer
    tpp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_ctl    (ctl),
        .o_busy   (busy)
    );

    // pen state and bitmap
    tpp_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // a row item only goes out while a print is in progress
    `TPP_ASSERT(a_strobe_busy, i_clk, i_rst_n, !o_strobe || busy)
    // the bottom row ends the print
    `TPP_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_strobe && o_result.last_row, !busy)
    // a taken print always starts a sweep
    `TPP_ASSERT_NEXT(a_print_busy, i_clk, i_rst_n, start && !busy && t_op'(i_cmd.op) == OP_PRINT, busy)

endmodule
